// File: hw/rtl/phb_pkg.sv
package phb_pkg;

	localparam int COORD_BITS_DEF      = 12;
	localparam int RATIO_FRAC_BITS_DEF = 12;

	localparam int PORT_COORD_BITS = 12;
	localparam int SCORE_BITS      = 11;
	localparam int MEAN_BITS       = 12;
	localparam int HEIGHT_BITS     = 12;
	localparam int WEIGHT_BITS     = 10;
	localparam int MPROD_BITS      = WEIGHT_BITS + 1 + MEAN_BITS;
	localparam int CORR_BITS       = 13;

	localparam logic [MEAN_BITS-1:0] MEAN_RESET = 12'd1700;

	// Confidence weight, Q0.10.
	localparam int WEIGHT_Q_BITS = 10;
	localparam int WEIGHT_MIN    = 307;
	localparam int WEIGHT_MAX    = 922;
	localparam int WEIGHT_ONE    = 1024;

	// Size correction, Q.12.
	localparam int SIZE_Q_BITS = 12;
	localparam logic [CORR_BITS-1:0] SIZE_UP_Q12   = 13'd4301;
	localparam logic [CORR_BITS-1:0] SIZE_DOWN_Q12 = 13'd3891;
	localparam logic [CORR_BITS-1:0] SIZE_ONE_Q12  = 13'd4096;
	localparam int AREA_HIGH = 10000;
	localparam int AREA_LOW  = 2000;

	localparam int HEIGHT_MIN = 800;
	localparam int HEIGHT_MAX = 2200;

	// Segment thresholds in tenths of the aspect ratio, bases and slopes in mm.
	localparam int TENTHS          = 10;
	localparam int TOP_TENTHS      = 24;
	localparam int HIGH_TENTHS     = 19;
	localparam int MID_TENTHS      = 16;
	localparam int LOW_TENTHS      = 11;
	localparam int TOP_BASE        = 1750;
	localparam int HIGH_BASE       = 1650;
	localparam int MID_BASE        = 1500;
	localparam int LOW_BASE        = 1200;
	localparam int TOP_SLOPE       = 200;
	localparam int HIGH_SLOPE      = 200;
	localparam int MID_SLOPE       = 500;
	localparam int LOW_SLOPE       = 600;
	localparam int TOP_CAP         = 160;
	localparam int FALLBACK_TENTHS = 7;

	// Exact division by ten of a 17-bit value.
	localparam int DIV10_BITS  = 17;
	localparam int DIV10_MUL   = 52429;
	localparam int DIV10_MBITS = 16;
	localparam int DIV10_SHIFT = 19;

	localparam int FRONT_STAGES = 3;
	localparam int POST_STAGES  = 7;

	typedef enum logic [1:0] {
		SZ_NOM,
		SZ_UP,
		SZ_DOWN
	} size_t;

	typedef struct packed {
		logic                   degen;
		size_t                  size;
		logic [WEIGHT_BITS-1:0] weight;
		logic [MPROD_BITS-1:0]  mprod;
	} side_t;

endpackage

// File: hw/rtl/phb_front.sv
module phb_front #(
	parameter int COORD_BITS = phb_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [phb_pkg::MEAN_BITS-1:0]        mean_height_mm,
	input  logic [phb_pkg::PORT_COORD_BITS-1:0]  box_left,
	input  logic [phb_pkg::PORT_COORD_BITS-1:0]  box_right,
	input  logic [phb_pkg::PORT_COORD_BITS-1:0]  box_top,
	input  logic [phb_pkg::PORT_COORD_BITS-1:0]  box_bottom,
	input  logic [phb_pkg::SCORE_BITS-1:0]       score_q10,
	output logic                                 valid,
	output logic [COORD_BITS-1:0]                box_w,
	output logic [COORD_BITS-1:0]                box_h,
	output phb_pkg::side_t                       side
);

	localparam int CW = COORD_BITS;
	localparam int AW = 2 * CW;
	localparam logic [AW-1:0] AREA_HI = AW'(phb_pkg::AREA_HIGH);
	localparam logic [AW-1:0] AREA_LO = AW'(phb_pkg::AREA_LOW);
	localparam logic [phb_pkg::SCORE_BITS-1:0] SCORE_MIN = phb_pkg::SCORE_BITS'(phb_pkg::WEIGHT_MIN);
	localparam logic [phb_pkg::SCORE_BITS-1:0] SCORE_MAX = phb_pkg::SCORE_BITS'(phb_pkg::WEIGHT_MAX);
	localparam logic [phb_pkg::WEIGHT_BITS:0] W_ONE = (phb_pkg::WEIGHT_BITS + 1)'(phb_pkg::WEIGHT_ONE);

	logic [CW-1:0] lft, rgt, top, bot, w_next, h_next;
	logic [phb_pkg::WEIGHT_BITS-1:0] weight_next;

	logic                            valid_s1, valid_s2, valid_s3;
	logic [CW-1:0]                   w_s1, h_s1, w_s2, h_s2, w_s3, h_s3;
	logic                            deg_s1, deg_s2;
	logic [phb_pkg::WEIGHT_BITS-1:0] weight_s1, weight_s2;
	logic [AW-1:0]                   area_s2;
	phb_pkg::side_t                  side_s3;
	phb_pkg::size_t                  size_next;
	logic [phb_pkg::WEIGHT_BITS:0]   wcomp;

	always_comb begin
		lft = CW'(box_left);
		rgt = CW'(box_right);
		top = CW'(box_top);
		bot = CW'(box_bottom);
		w_next = (rgt >= lft) ? rgt - lft : lft - rgt;
		h_next = (bot >= top) ? bot - top : top - bot;
		if (score_q10 < SCORE_MIN) begin
			weight_next = phb_pkg::WEIGHT_BITS'(SCORE_MIN);
		end else if (score_q10 > SCORE_MAX) begin
			weight_next = phb_pkg::WEIGHT_BITS'(SCORE_MAX);
		end else begin
			weight_next = score_q10[phb_pkg::WEIGHT_BITS-1:0];
		end
	end

	always_comb begin
		if (area_s2 > AREA_HI) begin
			size_next = phb_pkg::SZ_UP;
		end else if (area_s2 < AREA_LO) begin
			size_next = phb_pkg::SZ_DOWN;
		end else begin
			size_next = phb_pkg::SZ_NOM;
		end
		wcomp = W_ONE - {1'b0, weight_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		w_s1      <= w_next;
		h_s1      <= h_next;
		deg_s1    <= (w_next == '0) || (h_next == '0);
		weight_s1 <= weight_next;

		w_s2      <= w_s1;
		h_s2      <= h_s1;
		deg_s2    <= deg_s1;
		weight_s2 <= weight_s1;
		area_s2   <= AW'(w_s1) * AW'(h_s1);

		w_s3           <= w_s2;
		h_s3           <= h_s2;
		side_s3.degen  <= deg_s2;
		side_s3.size   <= size_next;
		side_s3.weight <= weight_s2;
		side_s3.mprod  <= phb_pkg::MPROD_BITS'(wcomp) * phb_pkg::MPROD_BITS'(mean_height_mm);
	end

	assign valid = valid_s3;
	assign box_w = w_s3;
	assign box_h = h_s3;
	assign side  = side_s3;

endmodule

// File: hw/rtl/phb_div.sv
module phb_div #(
	parameter int COORD_BITS      = phb_pkg::COORD_BITS_DEF,
	parameter int RATIO_FRAC_BITS = phb_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [COORD_BITS-1:0]                  box_w,
	input  logic [COORD_BITS-1:0]                  box_h,
	input  phb_pkg::side_t                         in_side,
	output logic                                   out_valid,
	output logic [COORD_BITS+RATIO_FRAC_BITS-1:0]  quo,
	output phb_pkg::side_t                         out_side
);

	localparam int CW = COORD_BITS;
	localparam int F  = RATIO_FRAC_BITS;
	localparam int QW = CW + F;
	localparam int PW = 2 * QW;

	// One quotient bit per stage, most significant first; the dividend is h << F.
	logic           valid_s [QW];
	logic [CW-1:0]  rem_s   [QW];
	logic [QW-1:0]  quo_s   [QW];
	logic [CW-1:0]  w_s     [QW];
	logic [CW-1:0]  h_s     [QW];
	phb_pkg::side_t side_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int BIT = QW - 1 - k;

		logic           valid_prev;
		logic [CW-1:0]  rem_prev, w_prev, h_prev, rem_next;
		logic [QW-1:0]  quo_prev, quo_next;
		phb_pkg::side_t side_prev;
		logic           nbit, take;
		logic [CW:0]    trial, diff;

		if (k == 0) begin : g_head
			assign valid_prev = in_valid;
			assign rem_prev   = '0;
			assign quo_prev   = '0;
			assign w_prev     = box_w;
			assign h_prev     = box_h;
			assign side_prev  = in_side;
		end else begin : g_body
			assign valid_prev = valid_s[k-1];
			assign rem_prev   = rem_s[k-1];
			assign quo_prev   = quo_s[k-1];
			assign w_prev     = w_s[k-1];
			assign h_prev     = h_s[k-1];
			assign side_prev  = side_s[k-1];
		end

		if (BIT >= F) begin : g_hbit
			assign nbit = h_prev[BIT-F];
		end else begin : g_zbit
			assign nbit = 1'b0;
		end

		always_comb begin
			trial    = {rem_prev, nbit};
			diff     = trial - {1'b0, w_prev};
			take     = trial >= {1'b0, w_prev};
			rem_next = take ? diff[CW-1:0] : trial[CW-1:0];
			quo_next = quo_prev;
			quo_next[BIT] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_prev;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_next;
			quo_s[k]  <= quo_next;
			w_s[k]    <= w_prev;
			h_s[k]    <= h_prev;
			side_s[k] <= side_prev;
		end
	end

	assign out_valid = valid_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[QW-1] && (w_s[QW-1] != '0) |->
		(PW'(quo_s[QW-1]) * PW'(w_s[QW-1]) + PW'(rem_s[QW-1]) == (PW'(h_s[QW-1]) << F))
		&& (rem_s[QW-1] < w_s[QW-1]))
		else $error("quotient and remainder do not reproduce the dividend");

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, QW))
		else $error("divider word appeared without an entering word");

endmodule

// File: hw/rtl/phb_post.sv
module phb_post #(
	parameter int COORD_BITS      = phb_pkg::COORD_BITS_DEF,
	parameter int RATIO_FRAC_BITS = phb_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [COORD_BITS+RATIO_FRAC_BITS-1:0]  quo,
	input  phb_pkg::side_t                         side,
	input  logic [phb_pkg::MEAN_BITS-1:0]          mean_height_mm,
	output logic                                   done,
	output logic [phb_pkg::HEIGHT_BITS-1:0]        height_mm,
	output logic                                   degenerate_box
);

	localparam int F  = RATIO_FRAC_BITS;
	localparam int QW = COORD_BITS + F;
	localparam int RW = F + 3;
	localparam int TW = F + 13;
	localparam int EW = F + 11;
	localparam int AW = EW + phb_pkg::CORR_BITS;
	localparam int BW = AW + phb_pkg::WEIGHT_BITS;
	localparam int MW = F + 35;
	localparam int NW = F + 37;
	localparam int YW = phb_pkg::DIV10_BITS;
	localparam int PW = YW + phb_pkg::DIV10_MBITS;
	localparam int HB = phb_pkg::HEIGHT_BITS;

	localparam logic [QW-1:0] RATIO_CAP = QW'(4) << F;
	localparam logic [QW-1:0] TH_TOP  = QW'((phb_pkg::TOP_TENTHS << F) / phb_pkg::TENTHS);
	localparam logic [QW-1:0] TH_HIGH = QW'((phb_pkg::HIGH_TENTHS << F) / phb_pkg::TENTHS);
	localparam logic [QW-1:0] TH_MID  = QW'((phb_pkg::MID_TENTHS << F) / phb_pkg::TENTHS);
	localparam logic [QW-1:0] TH_LOW  = QW'((phb_pkg::LOW_TENTHS << F) / phb_pkg::TENTHS);

	localparam logic [TW-1:0] BASE_TOP  = TW'(phb_pkg::TOP_BASE) << F;
	localparam logic [TW-1:0] BASE_HIGH = TW'(phb_pkg::HIGH_BASE) << F;
	localparam logic [TW-1:0] BASE_MID  = TW'(phb_pkg::MID_BASE) << F;
	localparam logic [TW-1:0] BASE_LOW  = TW'(phb_pkg::LOW_BASE) << F;
	localparam logic [TW-1:0] OFF_TOP   =
		TW'(phb_pkg::TOP_SLOPE * phb_pkg::TOP_TENTHS / phb_pkg::TENTHS) << F;
	localparam logic [TW-1:0] OFF_HIGH  =
		TW'(phb_pkg::HIGH_SLOPE * phb_pkg::HIGH_TENTHS / phb_pkg::TENTHS) << F;
	localparam logic [TW-1:0] OFF_MID   =
		TW'(phb_pkg::MID_SLOPE * phb_pkg::MID_TENTHS / phb_pkg::TENTHS) << F;
	localparam logic [TW-1:0] OFF_LOW   =
		TW'(phb_pkg::LOW_SLOPE * phb_pkg::LOW_TENTHS / phb_pkg::TENTHS) << F;
	localparam logic [TW-1:0] CAP_TOP   = TW'(phb_pkg::TOP_CAP) << F;

	localparam int SH_FB  = phb_pkg::SIZE_Q_BITS + phb_pkg::WEIGHT_Q_BITS;
	localparam int SH_SEG = SH_FB + F;
	localparam logic [NW-1:0] RND_FB  = NW'(phb_pkg::TENTHS / 2) << SH_FB;
	localparam logic [NW-1:0] RND_SEG = NW'(1) << (SH_SEG - 1);

	localparam logic [YW-1:0] H_MIN = YW'(phb_pkg::HEIGHT_MIN);
	localparam logic [YW-1:0] H_MAX = YW'(phb_pkg::HEIGHT_MAX);

	typedef enum logic [2:0] {
		SEG_TOP,
		SEG_HIGH,
		SEG_MID,
		SEG_LOW,
		SEG_FALLBACK
	} seg_t;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, done_q;

	seg_t                           seg_s1, seg_next;
	logic [RW-1:0]                  ratio_s1;
	phb_pkg::side_t                 side_s1, side_s2, side_s3, side_s4;
	logic [EW-1:0]                  est_s2;
	logic [phb_pkg::CORR_BITS-1:0]  corr_s2, corr_next;
	logic                           fb_s2, fb_s3, fb_s4, fb_s5, fb_s6;
	logic [AW-1:0]                  a_s3;
	logic [BW-1:0]                  b_s4;
	logic [MW-1:0]                  m_s4;
	logic [YW-1:0]                  y_s5, y_s6;
	logic                           deg_s5, deg_s6;
	logic [PW-1:0]                  prod_s6;
	logic [HB-1:0]                  height_q;
	logic                           degen_q;

	logic [TW-1:0] ratio_w, span, est_t;
	logic [NW-1:0] sum;
	logic [YW-1:0] y_next, val, clamped;

	// Stage 1: pick the segment on the raw quotient; saturate the ratio above 4.0.
	always_comb begin
		if (quo > TH_TOP) begin
			seg_next = SEG_TOP;
		end else if (quo > TH_HIGH) begin
			seg_next = SEG_HIGH;
		end else if (quo > TH_MID) begin
			seg_next = SEG_MID;
		end else if (quo > TH_LOW) begin
			seg_next = SEG_LOW;
		end else begin
			seg_next = SEG_FALLBACK;
		end
	end

	// Stage 2: segment estimate in 1/2^F mm; the fallback holds 7*mean in tenths.
	always_comb begin
		ratio_w = TW'(ratio_s1);
		span    = '0;
		unique case (seg_s1)
			SEG_TOP: begin
				span  = ratio_w * TW'(phb_pkg::TOP_SLOPE) - OFF_TOP;
				est_t = BASE_TOP + ((span > CAP_TOP) ? CAP_TOP : span);
			end
			SEG_HIGH: begin
				est_t = BASE_HIGH + ratio_w * TW'(phb_pkg::HIGH_SLOPE) - OFF_HIGH;
			end
			SEG_MID: begin
				est_t = BASE_MID + ratio_w * TW'(phb_pkg::MID_SLOPE) - OFF_MID;
			end
			SEG_LOW: begin
				est_t = BASE_LOW + ratio_w * TW'(phb_pkg::LOW_SLOPE) - OFF_LOW;
			end
			default: begin
				est_t = TW'(phb_pkg::FALLBACK_TENTHS) * TW'(mean_height_mm);
			end
		endcase
		unique case (side_s1.size)
			phb_pkg::SZ_UP:   corr_next = phb_pkg::SIZE_UP_Q12;
			phb_pkg::SZ_DOWN: corr_next = phb_pkg::SIZE_DOWN_Q12;
			default:          corr_next = phb_pkg::SIZE_ONE_Q12;
		endcase
	end

	// Stage 5: blend sum and rounding. Segment values divide by a power of two;
	// the fallback keeps a factor of ten for stage 6.
	always_comb begin
		sum = NW'(b_s4) + NW'(m_s4);
		if (fb_s4) begin
			y_next = YW'((sum + RND_FB) >> SH_FB);
		end else begin
			y_next = YW'((sum + RND_SEG) >> SH_SEG);
		end
	end

	always_comb begin
		val = fb_s6 ? YW'(prod_s6 >> phb_pkg::DIV10_SHIFT) : y_s6;
		if (val < H_MIN) begin
			clamped = H_MIN;
		end else if (val > H_MAX) begin
			clamped = H_MAX;
		end else begin
			clamped = val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			done_q   <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1   <= seg_next;
		ratio_s1 <= (quo > RATIO_CAP) ? RW'(RATIO_CAP) : quo[RW-1:0];
		side_s1  <= side;

		est_s2  <= est_t[EW-1:0];
		corr_s2 <= corr_next;
		fb_s2   <= (seg_s1 == SEG_FALLBACK);
		side_s2 <= side_s1;

		a_s3    <= AW'(corr_s2) * AW'(est_s2);
		fb_s3   <= fb_s2;
		side_s3 <= side_s2;

		b_s4    <= BW'(side_s3.weight) * BW'(a_s3);
		m_s4    <= fb_s3 ? (MW'(MW'(side_s3.mprod) * MW'(phb_pkg::TENTHS)) << phb_pkg::SIZE_Q_BITS)
		                 : (MW'(side_s3.mprod) << (F + phb_pkg::SIZE_Q_BITS));
		fb_s4   <= fb_s3;
		side_s4 <= side_s3;

		y_s5   <= y_next;
		fb_s5  <= fb_s4;
		deg_s5 <= side_s4.degen;

		prod_s6 <= PW'(y_s5) * PW'(phb_pkg::DIV10_MUL);
		y_s6    <= y_s5;
		fb_s6   <= fb_s5;
		deg_s6  <= deg_s5;

		height_q <= deg_s6 ? mean_height_mm : HB'(clamped);
		degen_q  <= deg_s6;
	end

	assign done           = done_q;
	assign height_mm      = height_q;
	assign degenerate_box = degen_q;

	a_post_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_valid, phb_pkg::POST_STAGES))
		else $error("result strobe without a matching quotient");

endmodule

// File: hw/rtl/person_height_from_box_core.sv
// Person height estimate from one detection box.
//
// A box is offered on box_left, box_right, box_top, box_bottom and score_q10
// and is taken at a rising clock edge where start is high and busy is low.
// busy stays low: the block is a pipeline that takes one box in every cycle.
// The height is on height_mm and degenerate_box for exactly one cycle, marked
// by done; results come out in the order the boxes went in. The pipeline is
// made of the ratio divider, which resolves one quotient bit per stage, plus
// three front stages (corner differences, area product, size class) and seven
// back stages (segment choice, segment estimate, two multiplies, blend
// rounding, divide by ten, clamp). The receiver cannot hold results off.
//
// The prior height is written over the cfg_valid/cfg_ready channel, with the
// word on mean_height_mm; cfg_ready is always high. Write it only while no box
// is in flight. Reset clears every valid bit and loads a prior of 1700 mm.
module person_height_from_box_core #(
	parameter int COORD_BITS      = phb_pkg::COORD_BITS_DEF,
	parameter int RATIO_FRAC_BITS = phb_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [phb_pkg::PORT_COORD_BITS-1:0]  box_left,
	input  logic [phb_pkg::PORT_COORD_BITS-1:0]  box_right,
	input  logic [phb_pkg::PORT_COORD_BITS-1:0]  box_top,
	input  logic [phb_pkg::PORT_COORD_BITS-1:0]  box_bottom,
	input  logic [phb_pkg::SCORE_BITS-1:0]       score_q10,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [phb_pkg::MEAN_BITS-1:0]        mean_height_mm,
	output logic                                 done,
	output logic [phb_pkg::HEIGHT_BITS-1:0]      height_mm,
	output logic                                 degenerate_box
);

	localparam int QW      = COORD_BITS + RATIO_FRAC_BITS;
	localparam int LATENCY = phb_pkg::FRONT_STAGES + QW + phb_pkg::POST_STAGES;

	logic [phb_pkg::MEAN_BITS-1:0] mean_q;

	logic                  front_valid, div_valid;
	logic [COORD_BITS-1:0] box_w, box_h;
	phb_pkg::side_t        front_side, div_side;
	logic [QW-1:0]         quo;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= phb_pkg::MEAN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mean_q <= mean_height_mm;
		end
	end

	phb_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start && !busy),
		.mean_height_mm (mean_q),
		.box_left       (box_left),
		.box_right      (box_right),
		.box_top        (box_top),
		.box_bottom     (box_bottom),
		.score_q10      (score_q10),
		.valid          (front_valid),
		.box_w          (box_w),
		.box_h          (box_h),
		.side           (front_side)
	);

	phb_div #(
		.COORD_BITS      (COORD_BITS),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.box_w     (box_w),
		.box_h     (box_h),
		.in_side   (front_side),
		.out_valid (div_valid),
		.quo       (quo),
		.out_side  (div_side)
	);

	phb_post #(
		.COORD_BITS      (COORD_BITS),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (div_valid),
		.quo            (quo),
		.side           (div_side),
		.mean_height_mm (mean_q),
		.done           (done),
		.height_mm      (height_mm),
		.degenerate_box (degenerate_box)
	);

	a_every_box_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted box produced no result at the expected cycle");

	a_height_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate_box |->
		(height_mm >= phb_pkg::HEIGHT_BITS'(phb_pkg::HEIGHT_MIN)) &&
		(height_mm <= phb_pkg::HEIGHT_BITS'(phb_pkg::HEIGHT_MAX)))
		else $error("estimated height outside the clamp range");

	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without an accepted box");

endmodule
